/* sv/tls_pkg.sv */
// ---------------------------------------------------------------------------
// tls_pkg
// Shared types and constants of the transient load sequencer.
// ---------------------------------------------------------------------------
package tls_pkg;

	localparam int unsigned CUR_W   = 16;  // milliamps
	localparam int unsigned TIME_W  = 17;  // milliseconds
	localparam int unsigned STEP_W  = 4;   // list step index
	localparam int unsigned US_W    = 32;  // microsecond timestamp
	localparam int unsigned LIM_W   = 27;  // TIME_W ms scaled to us
	localparam int unsigned CFG_IW  = 3;   // config register index
	localparam int unsigned CFG_DW  = 17;  // config write data
	localparam int unsigned OQ_DEPTH = 4;
	localparam int unsigned OQ_AW    = 2;
	localparam int unsigned OQ_CW    = 3;

	localparam logic [LIM_W-1:0] US_PER_MS = LIM_W'(1000);

	localparam logic ACT_TICK  = 1'b0;
	localparam logic ACT_WRITE = 1'b1;

	localparam logic MODE_TOGGLE = 1'b0;
	localparam logic MODE_LIST   = 1'b1;

	typedef enum logic [CFG_IW-1:0] {
		CFG_MODE    = 3'd0,
		CFG_LOW     = 3'd1,
		CFG_HIGH    = 3'd2,
		CFG_PERIOD  = 3'd3,
		CFG_FINAL   = 3'd4,
		CFG_CUTOFF  = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [CUR_W-1:0]  cur_ma;
		logic [TIME_W-1:0] time_ms;
	} entry_t;

	typedef struct packed {
		logic              en;
		logic [STEP_W-1:0] idx;
		entry_t            entry;
	} tbl_wr_t;

	typedef struct packed {
		logic [CUR_W-1:0]  setpoint_ma;
		logic [STEP_W-1:0] step_shown;
		logic              run_end;
	} res_t;

endpackage

/* sv/tls_if.sv */
// ---------------------------------------------------------------------------
// tls_if
// Valid/ready channels of the sequencer: tick/entry requests, setpoint
// results and configuration writes.
// ---------------------------------------------------------------------------
interface tls_item_if;
	logic                          valid;
	logic                          ready;
	logic                          action;
	logic                          load_on;
	logic [tls_pkg::US_W-1:0]      now_us;
	logic [tls_pkg::STEP_W-1:0]    entry_index;
	logic [tls_pkg::CUR_W-1:0]     entry_current_ma;
	logic [tls_pkg::TIME_W-1:0]    entry_time_ms;

	modport source (output valid, action, load_on, now_us, entry_index,
		entry_current_ma, entry_time_ms, input ready);
	modport sink (input valid, action, load_on, now_us, entry_index,
		entry_current_ma, entry_time_ms, output ready);
endinterface

interface tls_res_if;
	logic                          valid;
	logic                          ready;
	logic [tls_pkg::CUR_W-1:0]     setpoint_ma;
	logic [tls_pkg::STEP_W-1:0]    step_shown;
	logic                          run_end;

	modport source (output valid, setpoint_ma, step_shown, run_end, input ready);
	modport sink (input valid, setpoint_ma, step_shown, run_end, output ready);
endinterface

interface tls_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [tls_pkg::CFG_IW-1:0]    index;
	logic [tls_pkg::CFG_DW-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* sv/tls_table.sv */
// ---------------------------------------------------------------------------
// tls_table
// List step table: one write port, one addressed read, step 0 tapped.
// ---------------------------------------------------------------------------
module tls_table #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tls_pkg::tbl_wr_t  wr,
	input  logic [AW-1:0]     rd_idx,
	output tls_pkg::entry_t   rd_entry,
	output tls_pkg::entry_t   entry0
);

	tls_pkg::entry_t tbl_q [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				tbl_q[i] <= '0;
			end
		end else if (wr.en && (32'(wr.idx) < DEPTH)) begin
			tbl_q[wr.idx[AW-1:0]] <= wr.entry;
		end
	end

	// out-of-range slots (non power-of-two depth) read as empty
	assign rd_entry = (32'(rd_idx) < DEPTH) ? tbl_q[rd_idx] : '0;
	assign entry0   = tbl_q[0];

endmodule

/* sv/tls_outq.sv */
// ---------------------------------------------------------------------------
// tls_outq
// Result queue: takes up to two results a cycle, gives one a cycle if ready.
// ---------------------------------------------------------------------------
module tls_outq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [1:0]     push_n,
	input  tls_pkg::res_t  d0,
	input  tls_pkg::res_t  d1,
	output logic           room,
	tls_res_if.source      res
);

	tls_pkg::res_t                 mem_q [tls_pkg::OQ_DEPTH];
	logic [tls_pkg::OQ_AW-1:0]     wp_q;
	logic [tls_pkg::OQ_AW-1:0]     rp_q;
	logic [tls_pkg::OQ_CW-1:0]     cnt_q;
	logic                          pop;

	assign pop  = res.valid && res.ready;
	assign room = (cnt_q <= tls_pkg::OQ_CW'(2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + tls_pkg::OQ_AW'(push_n);
			rp_q  <= rp_q + tls_pkg::OQ_AW'(pop);
			cnt_q <= cnt_q + tls_pkg::OQ_CW'(push_n) - tls_pkg::OQ_CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wp_q] <= d0;
		end
		if (push_n == 2'd2) begin
			mem_q[wp_q + tls_pkg::OQ_AW'(1)] <= d1;
		end
	end

	assign res.valid       = (cnt_q != '0);
	assign res.setpoint_ma = mem_q[rp_q].setpoint_ma;
	assign res.step_shown  = mem_q[rp_q].step_shown;
	assign res.run_end     = mem_q[rp_q].run_end;

endmodule

/* sv/transient_load_sequencer.sv */
// ---------------------------------------------------------------------------
// transient_load_sequencer
// Electronic load setpoint sequencer: continuous two-level toggle or a
// stepped (current, time) list driven by microsecond ticks.
// ---------------------------------------------------------------------------
// Flow: a request is registered in the input register at acceptance and
//   processed from there; a tick waits there while the result queue lacks
//   room. Its results are written into the queue, from which they are read.
// Rate: one request per cycle while the queue has room for ticks; two
//   setpoints of one tick leave in turn via the one-result-a-cycle queue.
// Reset (arst_n low): registers to defaults, step table cleared at once.
// ---------------------------------------------------------------------------
module transient_load_sequencer #(
	parameter int unsigned MAX_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	tls_item_if.sink    item,
	tls_res_if.source   result,
	tls_cfg_if.sink     cfg
);

	// only the first 16 slots are writable (4-bit entry index); the rest
	// of the list stays zero forever and needs no storage
	localparam int unsigned TBL_DEPTH = (MAX_STEPS < 16) ? MAX_STEPS : 16;
	localparam int unsigned TBL_AW    = $clog2(TBL_DEPTH);

	// ---------------- configuration registers ----------------
	logic                          mode_q;
	logic [tls_pkg::CUR_W-1:0]     low_q;
	logic [tls_pkg::CUR_W-1:0]     high_q;
	logic [tls_pkg::TIME_W-1:0]    period_q;
	logic [tls_pkg::STEP_W-1:0]    final_q;
	logic [tls_pkg::CUR_W-1:0]     cutoff_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= tls_pkg::MODE_TOGGLE;
			low_q    <= '0;
			high_q   <= '0;
			period_q <= '0;
			final_q  <= tls_pkg::STEP_W'(1);
			cutoff_q <= '1;
		end else if (cfg.valid) begin
			case (tls_pkg::cfg_idx_t'(cfg.index))
				tls_pkg::CFG_MODE:   mode_q   <= cfg.data[0];
				tls_pkg::CFG_LOW:    low_q    <= cfg.data[tls_pkg::CUR_W-1:0];
				tls_pkg::CFG_HIGH:   high_q   <= cfg.data[tls_pkg::CUR_W-1:0];
				tls_pkg::CFG_PERIOD: period_q <= cfg.data[tls_pkg::TIME_W-1:0];
				tls_pkg::CFG_FINAL:  final_q  <= cfg.data[tls_pkg::STEP_W-1:0];
				tls_pkg::CFG_CUTOFF: cutoff_q <= cfg.data[tls_pkg::CUR_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- input register ----------------
	logic                          v_s1;
	logic                          act_s1;
	logic                          on_s1;
	logic [tls_pkg::US_W-1:0]      now_s1;
	logic [tls_pkg::STEP_W-1:0]    idx_s1;
	logic [tls_pkg::CUR_W-1:0]     ecur_s1;
	logic [tls_pkg::TIME_W-1:0]    etime_s1;
	logic                          room;
	logic                          fire;

	// table writes never produce results, so only ticks wait on queue room
	assign fire       = v_s1 && ((act_s1 == tls_pkg::ACT_WRITE) || room);
	assign item.ready = !v_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item.ready) begin
			v_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			act_s1   <= item.action;
			on_s1    <= item.load_on;
			now_s1   <= item.now_us;
			idx_s1   <= item.entry_index;
			ecur_s1  <= item.entry_current_ma;
			etime_s1 <= item.entry_time_ms;
		end
	end

	// ---------------- sequencer state ----------------
	logic [tls_pkg::US_W-1:0]      last_q;    // time of last change, 0 = fresh list start
	logic                          tog_q;     // 1: high level next
	logic [tls_pkg::STEP_W-1:0]    step_q;
	logic [tls_pkg::TIME_W-1:0]    active_q;  // dwell of the running list step
	tls_pkg::entry_t               shadow_q;  // copy of table[step_q], kept coherent

	// ---------------- step table ----------------
	tls_pkg::tbl_wr_t              tbl_wr;
	tls_pkg::entry_t               nxt_entry;
	tls_pkg::entry_t               entry0;
	logic [tls_pkg::STEP_W:0]      step_inc;
	logic                          wrap;
	logic [tls_pkg::STEP_W-1:0]    nxt_step;

	always_comb begin
		tbl_wr.en            = fire && (act_s1 == tls_pkg::ACT_WRITE);
		tbl_wr.idx           = idx_s1;
		tbl_wr.entry.cur_ma  = (ecur_s1 < cutoff_q) ? ecur_s1 : cutoff_q;
		tbl_wr.entry.time_ms = etime_s1;
	end

	// step after the current one, wrapping past final_step or the list end
	assign step_inc = {1'b0, step_q} + (tls_pkg::STEP_W + 1)'(1);
	assign wrap     = (step_inc > {1'b0, final_q}) || (32'(step_inc) >= MAX_STEPS);
	assign nxt_step = wrap ? '0 : step_inc[tls_pkg::STEP_W-1:0];

	tls_table #(
		.DEPTH (TBL_DEPTH),
		.AW    (TBL_AW)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (tbl_wr),
		.rd_idx   (nxt_step[TBL_AW-1:0]),
		.rd_entry (nxt_entry),
		.entry0   (entry0)
	);

	// ---------------- tick evaluation ----------------
	logic                          tick;
	logic                          fresh;
	logic [tls_pkg::US_W-1:0]      base_us;
	logic [tls_pkg::TIME_W-1:0]    dwell_ms;
	logic [tls_pkg::US_W-1:0]      elapsed;
	logic [tls_pkg::LIM_W-1:0]     limit_us;
	logic                          due;
	logic [tls_pkg::CUR_W-1:0]     lvl;
	logic [1:0]                    push_n;
	tls_pkg::res_t                 d0;
	tls_pkg::res_t                 d1;

	assign tick  = fire && (act_s1 == tls_pkg::ACT_TICK) && on_s1;
	assign fresh = (mode_q == tls_pkg::MODE_LIST) && (last_q == '0);

	// a fresh list start restarts the clock at now with the step's own dwell
	always_comb begin
		if (mode_q == tls_pkg::MODE_TOGGLE) begin
			base_us  = last_q;
			dwell_ms = period_q;
		end else if (fresh) begin
			base_us  = now_s1;
			dwell_ms = shadow_q.time_ms;
		end else begin
			base_us  = last_q;
			dwell_ms = active_q;
		end
	end

	assign elapsed  = now_s1 - base_us;  // wraps mod 2^32
	assign limit_us = tls_pkg::LIM_W'(dwell_ms) * tls_pkg::US_PER_MS;
	assign due      = elapsed >= tls_pkg::US_W'(limit_us);

	assign lvl = tog_q ? high_q : low_q;

	always_comb begin
		push_n = 2'd0;
		d0     = '0;
		d1     = '0;
		if (tick) begin
			if (mode_q == tls_pkg::MODE_TOGGLE) begin
				if (due) begin
					push_n         = 2'd1;
					d0.setpoint_ma = (lvl < cutoff_q) ? lvl : cutoff_q;
					d0.step_shown  = '0;
					d0.run_end     = 1'b1;
				end
			end else begin
				// fresh start emits the current step; a due dwell adds the next
				d1.setpoint_ma = nxt_entry.cur_ma;
				d1.step_shown  = nxt_step;
				d1.run_end     = 1'b1;
				if (fresh) begin
					d0.setpoint_ma = shadow_q.cur_ma;
					d0.step_shown  = step_q;
					d0.run_end     = !due;
					push_n         = due ? 2'd2 : 2'd1;
				end else if (due) begin
					d0     = d1;
					push_n = 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q   <= '0;
			tog_q    <= 1'b0;
			step_q   <= '0;
			active_q <= '0;
			shadow_q <= '0;
		end else if (fire) begin
			if (act_s1 == tls_pkg::ACT_WRITE) begin
				if ((32'(idx_s1) < MAX_STEPS) && (idx_s1 == step_q)) begin
					shadow_q <= tbl_wr.entry;
				end
			end else if (!on_s1) begin
				// load off: back to step 0, low level, fresh start
				last_q   <= '0;
				tog_q    <= 1'b0;
				step_q   <= '0;
				active_q <= entry0.time_ms;
				shadow_q <= entry0;
			end else if (mode_q == tls_pkg::MODE_TOGGLE) begin
				if (due) begin
					last_q <= now_s1;
					tog_q  <= !tog_q;
				end
			end else if (due) begin
				last_q   <= now_s1;
				step_q   <= nxt_step;
				active_q <= nxt_entry.time_ms;
				shadow_q <= nxt_entry;
			end else if (fresh) begin
				last_q   <= now_s1;
				active_q <= shadow_q.time_ms;
			end
		end
	end

	// ---------------- result queue ----------------
	tls_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push_n (push_n),
		.d0     (d0),
		.d1     (d1),
		.room   (room),
		.res    (result)
	);

endmodule
